[rtl/rkjct_pkg.sv]
// Shared types, register indexes and saturation helper for the column transport unit.
package rkjct_pkg;

   localparam int VecWidth     = 60;
   localparam int CompWidth    = 20;
   localparam int OneThirdQ24  = 5592405;
   localparam int PipeDepth    = 12;

   typedef logic [2:0][31:0] vec_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic               last_column;
   } in_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_dir_x;
      logic signed [31:0] new_dir_y;
      logic signed [31:0] new_dir_z;
   } out_type;

   typedef enum logic [2:0] {
      CSR_FIELD_H0   = 3'd0,
      CSR_FIELD_H1   = 3'd1,
      CSR_FIELD_H2   = 3'd2,
      CSR_OFFSET_V0  = 3'd3,
      CSR_OFFSET_V3  = 3'd4,
      CSR_OFFSET_V4  = 3'd5,
      CSR_OFFSET_V6  = 3'd6,
      CSR_STEP_SCALE = 3'd7
   } csr_idx_type;

   // Clamp to signed 32 bits.
   function automatic logic [31:0] sat32(input logic signed [67:0] x);
      logic [31:0] r;
      if (x > 68'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -68'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/rkjct_cross.sv]
// Two-stage cross product with floor shift, addends and saturation.
module rkjct_cross (
   input  logic                      clock,
   input  rkjct_pkg::vec_type        a_in,
   input  logic [59:0]               field_in,
   input  rkjct_pkg::vec_type        base_in,
   input  logic [59:0]               addend_in,
   output rkjct_pkg::vec_type        d_out
);
   import rkjct_pkg::*;

   logic signed [31:0] a_s [3];
   logic signed [19:0] h_s [3];
   logic signed [52:0] c_in [3];
   logic signed [52:0] c_ff [3];
   vec_type            d_in;
   vec_type            d_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_s[k] = $signed(a_in[k]);
         h_s[k] = $signed(field_in[CompWidth*k +: CompWidth]);
      end
      c_in[0] = 53'(a_s[1]) * 53'(h_s[2]) - 53'(a_s[2]) * 53'(h_s[1]);
      c_in[1] = 53'(a_s[2]) * 53'(h_s[0]) - 53'(a_s[0]) * 53'(h_s[2]);
      c_in[2] = 53'(a_s[0]) * 53'(h_s[1]) - 53'(a_s[1]) * 53'(h_s[0]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = sat32(68'(c_ff[k] >>> 16) + 68'($signed(base_in[k]))
                         + 68'($signed(addend_in[CompWidth*k +: CompWidth])));
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      d_ff <= d_in;
   end

   assign d_out = d_ff;

endmodule

[rtl/rk_jacobian_column_transport_unit.sv]
// Top level: pipelined Runge-Kutta-Nystrom Jacobian column transport.
// Throughput: one column per cycle; busy stays low, start is taken every cycle.
// Four chained two-stage cross units set the depth, then sum, multiply, clamp.
// Reset (synchronous, active high) clears the in-flight valid bits and the configuration registers.
// The receiver cannot stall; each result word is shown for exactly one cycle.
module rk_jacobian_column_transport_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rkjct_pkg::in_type  req_word,
   output logic               rsp_valid,
   output rkjct_pkg::out_type rsp_word,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_addr,
   input  logic [59:0]        csr_wdata
);
   import rkjct_pkg::*;

   // Configuration registers.
   logic [59:0] h0_ff, h1_ff, h2_ff, v0_ff, v3_ff, v4_ff, v6_ff;
   logic [31:0] s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_ff <= '0; h1_ff <= '0; h2_ff <= '0;
         v0_ff <= '0; v3_ff <= '0; v4_ff <= '0; v6_ff <= '0;
         s3_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_addr))
            CSR_FIELD_H0:   h0_ff <= csr_wdata;
            CSR_FIELD_H1:   h1_ff <= csr_wdata;
            CSR_FIELD_H2:   h2_ff <= csr_wdata;
            CSR_OFFSET_V0:  v0_ff <= csr_wdata;
            CSR_OFFSET_V3:  v3_ff <= csr_wdata;
            CSR_OFFSET_V4:  v4_ff <= csr_wdata;
            CSR_OFFSET_V6:  v6_ff <= csr_wdata;
            CSR_STEP_SCALE: s3_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Never stalls: a new column may enter every cycle.
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Valid bits travel alongside the data, one per level.
   logic [PipeDepth-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[PipeDepth-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Sideband delay lines: dA to level 6, dR to level 10, flag to level 7.
   vec_type da_ff [0:6];
   vec_type dr_ff [0:10];
   logic    last_ff [0:7];

   always_ff @(posedge clock) begin
      da_ff[0]   <= {req_word.dir_z, req_word.dir_y, req_word.dir_x};
      dr_ff[0]   <= {req_word.pos_z, req_word.pos_y, req_word.pos_x};
      last_ff[0] <= req_word.last_column;
      for (int i = 1; i <= 6; i++) da_ff[i] <= da_ff[i-1];
      for (int i = 1; i <= 10; i++) dr_ff[i] <= dr_ff[i-1];
      for (int i = 1; i <= 7; i++) last_ff[i] <= last_ff[i-1];
   end

   // Chained cross products: d0 at level 2, d3 at 4, d4 at 6, d6 at 8.
   vec_type d0_w, d3_w, d4_w, d6_w, d2_w, d5_w;
   logic [59:0] add0, add3, add4, add6;

   assign add0 = last_ff[1] ? v0_ff : '0;
   assign add3 = last_ff[3] ? v3_ff : '0;
   assign add4 = last_ff[5] ? v4_ff : '0;
   assign add6 = last_ff[7] ? v6_ff : '0;

   rkjct_cross u_cross_d0 (
      .clock(clock), .a_in(da_ff[0]), .field_in(h0_ff),
      .base_in('0), .addend_in(add0), .d_out(d0_w));

   // d2 = d0 + dA, formed at level 2.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d2_w[k] = sat32(68'($signed(d0_w[k])) + 68'($signed(da_ff[2][k])));
      end
   end

   rkjct_cross u_cross_d3 (
      .clock(clock), .a_in(d2_w), .field_in(h1_ff),
      .base_in(da_ff[3]), .addend_in(add3), .d_out(d3_w));

   rkjct_cross u_cross_d4 (
      .clock(clock), .a_in(d3_w), .field_in(h1_ff),
      .base_in(da_ff[5]), .addend_in(add4), .d_out(d4_w));

   // d5 = 2*d4 - dA, formed at level 6.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d5_w[k] = sat32(68'($signed(d4_w[k])) * 68'sd2 - 68'($signed(da_ff[6][k])));
      end
   end

   rkjct_cross u_cross_d6 (
      .clock(clock), .a_in(d5_w), .field_in(h2_ff),
      .base_in('0), .addend_in(add6), .d_out(d6_w));

   // Hold the intermediates until level 8, where d6 arrives.
   vec_type d0_ff [3:8];
   vec_type d2_ff [3:8];
   vec_type d3_ff [5:8];
   vec_type d4_ff [7:8];
   vec_type d5_ff [7:8];

   always_ff @(posedge clock) begin
      d0_ff[3] <= d0_w;
      d2_ff[3] <= d2_w;
      for (int i = 4; i <= 8; i++) begin
         d0_ff[i] <= d0_ff[i-1];
         d2_ff[i] <= d2_ff[i-1];
      end
      d3_ff[5] <= d3_w;
      for (int i = 6; i <= 8; i++) d3_ff[i] <= d3_ff[i-1];
      d4_ff[7] <= d4_w;
      d4_ff[8] <= d4_ff[7];
      d5_ff[7] <= d5_w;
      d5_ff[8] <= d5_ff[7];
   end

   // Level 8 -> 9: exact sums.
   logic signed [33:0] ps_in [3];
   logic signed [34:0] ds_in [3];
   logic signed [33:0] ps_ff [3];
   logic signed [34:0] ds_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ps_in[k] = 34'($signed(d2_ff[8][k])) + 34'($signed(d3_ff[8][k]))
                  + 34'($signed(d4_ff[8][k]));
         ds_in[k] = 35'($signed(d0_ff[8][k])) + 35'($signed(d3_ff[8][k])) * 35'sd2
                  + 35'($signed(d5_ff[8][k])) + 35'($signed(d6_w[k]));
      end
   end

   // Level 9 -> 10: scale by S3 and by one third.
   logic signed [65:0] pm_in [3];
   logic signed [59:0] dm_in [3];
   logic signed [65:0] pm_ff [3];
   logic signed [59:0] dm_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pm_in[k] = 66'(ps_ff[k]) * 66'($signed(s3_ff));
         dm_in[k] = 60'(ds_ff[k]) * 60'(OneThirdQ24);
      end
   end

   // Level 10 -> 11: floor, add dR, clamp into the output word.
   out_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.new_pos_x = sat32(68'(pm_ff[0] >>> 16) + 68'($signed(dr_ff[10][0])));
      rsp_in.new_pos_y = sat32(68'(pm_ff[1] >>> 16) + 68'($signed(dr_ff[10][1])));
      rsp_in.new_pos_z = sat32(68'(pm_ff[2] >>> 16) + 68'($signed(dr_ff[10][2])));
      rsp_in.new_dir_x = sat32(68'(dm_ff[0] >>> 24));
      rsp_in.new_dir_y = sat32(68'(dm_ff[1] >>> 24));
      rsp_in.new_dir_z = sat32(68'(dm_ff[2] >>> 24));
   end

   always_ff @(posedge clock) begin
      ps_ff  <= ps_in;
      ds_ff  <= ds_in;
      pm_ff  <= pm_in;
      dm_ff  <= dm_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[PipeDepth-1];
   assign rsp_word  = rsp_ff;

endmodule

[rtl/rkjct_checker.sv]
// Port-level checker for the column transport unit, with its bind.
module rkjct_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import rkjct_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_word_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##12 rsp_valid)
      else $error("accepted word not returned after 12 cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 12))
      else $error("result word without a matching accepted word");

endmodule

bind rk_jacobian_column_transport_unit rkjct_checker u_rkjct_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid));

[sim/tb.sv]
// Self-checking testbench for the Jacobian column transport unit.
`timescale 1ns / 1ps

module tb;
   import rkjct_pkg::*;

   typedef logic signed [127:0] wide_type;

   // One row of the directed stimulus; the expected word is typed in where it
   // follows from the reset configuration at a glance.
   typedef struct {
      in_type  w;
      bit      has_exp;
      out_type exp;
   } row_type;

   localparam int WatchLimit = 4000;
   localparam int Phases     = 6;
   localparam int RandPerPhase = 215;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   in_type      req_word = '0;
   logic        rsp_valid;
   out_type     rsp_word;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [59:0] csr_wdata = '0;

   // Shadow copy of the register file used by the column predictor.
   logic [59:0] field_vec [7];
   logic [31:0] scale_reg;

   out_type     pending_cols [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          idle_on = 1'b1;
   row_type     rows [$];

   rk_jacobian_column_transport_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic wide_type clamp32(wide_type x);
      if (x > 128'sd2147483647) return 128'sd2147483647;
      if (x < -128'sd2147483648) return -128'sd2147483648;
      return x;
   endfunction

   function automatic void unpack_vec(input logic [59:0] r, output wide_type v[3]);
      logic signed [19:0] c;
      for (int k = 0; k < 3; k++) begin
         c = r[k*20 +: 20];
         v[k] = c;
      end
   endfunction

   // o = clamp(floor((a x h) / 2^16) + base + add), per component
   function automatic void cross_acc(input wide_type a[3], input wide_type h[3],
                                     input wide_type base[3], input wide_type add[3],
                                     output wide_type o[3]);
      wide_type c[3];
      c[0] = a[1] * h[2] - a[2] * h[1];
      c[1] = a[2] * h[0] - a[0] * h[2];
      c[2] = a[0] * h[1] - a[1] * h[0];
      for (int k = 0; k < 3; k++) o[k] = clamp32((c[k] >>> 16) + base[k] + add[k]);
   endfunction

   function automatic out_type transport_column(in_type w);
      wide_type dr[3], da[3], h0[3], h1[3], h2[3];
      wide_type v0[3], v3[3], v4[3], v6[3], nil[3];
      wide_type d0[3], d2[3], d3[3], d4[3], d5[3], d6[3];
      wide_type s3, ps, ds;
      logic signed [31:0] s3_raw;
      logic [31:0] np[3], nd[3];
      out_type r;
      dr[0] = w.pos_x; dr[1] = w.pos_y; dr[2] = w.pos_z;
      da[0] = w.dir_x; da[1] = w.dir_y; da[2] = w.dir_z;
      unpack_vec(field_vec[CSR_FIELD_H0], h0);
      unpack_vec(field_vec[CSR_FIELD_H1], h1);
      unpack_vec(field_vec[CSR_FIELD_H2], h2);
      unpack_vec(w.last_column ? field_vec[CSR_OFFSET_V0] : 60'd0, v0);
      unpack_vec(w.last_column ? field_vec[CSR_OFFSET_V3] : 60'd0, v3);
      unpack_vec(w.last_column ? field_vec[CSR_OFFSET_V4] : 60'd0, v4);
      unpack_vec(w.last_column ? field_vec[CSR_OFFSET_V6] : 60'd0, v6);
      unpack_vec(60'd0, nil);
      s3_raw = scale_reg;
      s3 = s3_raw;
      cross_acc(da, h0, nil, v0, d0);
      for (int k = 0; k < 3; k++) d2[k] = clamp32(d0[k] + da[k]);
      cross_acc(d2, h1, da, v3, d3);
      cross_acc(d3, h1, da, v4, d4);
      for (int k = 0; k < 3; k++) d5[k] = clamp32(2 * d4[k] - da[k]);
      cross_acc(d5, h2, nil, v6, d6);
      for (int k = 0; k < 3; k++) begin
         ps = d2[k] + d3[k] + d4[k];
         np[k] = 32'(clamp32(dr[k] + ((ps * s3) >>> 16)));
         ds = d0[k] + 2 * d3[k] + d5[k] + d6[k];
         nd[k] = 32'(clamp32((ds * 128'sd5592405) >>> 24));
      end
      r.new_pos_x = np[0]; r.new_pos_y = np[1]; r.new_pos_z = np[2];
      r.new_dir_x = nd[0]; r.new_dir_y = nd[1]; r.new_dir_z = nd[2];
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
   endtask

   string field_names [6] = '{"new_pos_x", "new_pos_y", "new_pos_z",
                              "new_dir_x", "new_dir_y", "new_dir_z"};

   // Compare every result word with the oldest expectation; count idle cycles.
   always @(posedge clock) begin
      out_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("FAILURE");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_cols.size() == 0) begin
               report_mismatch("unexpected word", rsp_word[191:160], 32'h0);
            end else begin
               want = pending_cols.pop_front();
               for (int i = 0; i < 6; i++)
                  if (rsp_word[(5-i)*32 +: 32] !== want[(5-i)*32 +: 32])
                     report_mismatch(field_names[i], rsp_word[(5-i)*32 +: 32],
                                     want[(5-i)*32 +: 32]);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_reg(csr_idx_type idx, logic [59:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      if (idx == CSR_STEP_SCALE) scale_reg = data[31:0];
      else field_vec[idx] = data;
      @(posedge clock);
   endtask

   // Hold one column on the request port until the unit takes it.
   task automatic send_column(in_type w, bit has_exp, out_type exp);
      if (idle_on && $urandom_range(0, 99) < 19) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_cols.push_back(has_exp ? exp : transport_column(w));
   endtask

   // Drop start and wait until every result word has drained.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_cols.size() != 0) @(posedge clock);
      repeat (PipeDepth + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'($signed($urandom_range(0, 8191)) - 4096);
         4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [59:0] pick_vec();
      logic [59:0] v;
      for (int k = 0; k < 3; k++)
         case ($urandom_range(0, 5))
            0: v[k*20 +: 20] = 20'h7FFFF;
            1: v[k*20 +: 20] = 20'h80000;
            2: v[k*20 +: 20] = 20'h0;
            default: v[k*20 +: 20] = 20'($urandom);
         endcase
      return v;
   endfunction

   function automatic in_type pick_column();
      in_type w;
      w.pos_x = pick_word(); w.pos_y = pick_word(); w.pos_z = pick_word();
      w.dir_x = pick_word(); w.dir_y = pick_word(); w.dir_z = pick_word();
      w.last_column = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic row_type mk_row(logic [31:0] p, logic [31:0] d, logic last,
                                      bit has_exp, logic [31:0] ep, logic [31:0] ed);
      row_type r;
      r.w = '{p, p, p, d, d, d, last};
      r.has_exp = has_exp;
      r.exp = '{ep, ep, ep, ed, ed, ed};
      return r;
   endfunction

   initial begin
      logic [59:0] v;
      logic [31:0] s;
      foreach (field_vec[i]) field_vec[i] = '0;
      scale_reg = '0;

      // With every register at zero: new_pos = dR, and new_dir is
      // floor(3*dA*(2^24-1)/3 / 2^24), which drops one LSB off a small positive dA.
      rows.push_back(mk_row(32'h0, 32'h0, 1'b0, 1, 32'h0, 32'h0));
      rows.push_back(mk_row(32'h7FFF_FFFF, 32'h0, 1'b0, 1, 32'h7FFF_FFFF, 32'h0));
      rows.push_back(mk_row(32'h8000_0000, 32'h0, 1'b1, 1, 32'h8000_0000, 32'h0));
      rows.push_back(mk_row(32'h1234_5678, 32'h1, 1'b0, 1, 32'h1234_5678, 32'h0));
      rows.push_back(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
      rows.push_back(mk_row(32'h0, 32'h7FFF_FFFF, 1'b0, 0, 0, 0));
      rows.push_back(mk_row(32'h0, 32'h8000_0000, 1'b1, 0, 0, 0));
      rows.push_back(mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 0, 0, 0));
      rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 1'b0, 0, 0, 0));
      rows.push_back(mk_row(32'h0001_0000, 32'h0001_0000, 1'b1, 0, 0, 0));
      rows.push_back(mk_row(32'hFFFF_0000, 32'h0000_8000, 1'b0, 0, 0, 0));
      rows.push_back(mk_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 0, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < Phases; ph++) begin
         // Reconfigure only once the pipe has emptied; the first phase runs at
         // the reset values, the next two at the component extremes.
         if (ph > 0) begin
            drain();
            for (int i = 0; i < 7; i++) begin
               case (ph)
                  1: v = {3{20'h7FFFF}};
                  2: v = {3{20'h80000}};
                  default: v = pick_vec();
               endcase
               write_reg(csr_idx_type'(i), v);
            end
            case (ph)
               1: s = 32'h7FFF_FFFF;
               2: s = 32'h8000_0000;
               3: s = 32'h0001_0000;
               default: s = pick_word();
            endcase
            write_reg(CSR_STEP_SCALE, {28'h0, s});
            csr_wr_en <= 1'b0;
            @(posedge clock);
         end
         idle_on = (ph != 3);
         if (ph < 2)
            foreach (rows[i])
               send_column(rows[i].w, ph == 0 && rows[i].has_exp, rows[i].exp);
         for (int n = 0; n < RandPerPhase; n++)
            send_column(pick_column(), 1'b0, '0);
      end

      drain();
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
